### hdl/linear_assignment_solver_unit_defines.svh
// Assertion macros for the linear assignment solver.
`ifndef LINEAR_ASSIGNMENT_SOLVER_UNIT_DEFINES_SVH
`define LINEAR_ASSIGNMENT_SOLVER_UNIT_DEFINES_SVH
// Property checked on every rising edge, off while in reset.
`define LAS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Signal never X or Z on a rising edge, off while in reset.
`define LAS_ASSERT_KNOWN(label, sig, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !$isunknown(sig)) else $error(msg);
`endif

### hdl/las_pkg.sv
// Package: constants, types and the state encoding of the assignment solver.
`timescale 1ns / 1ps
package las_pkg;
  localparam int unsigned MaxSide = 16;
  localparam int unsigned IdxW = 4;
  localparam int unsigned CntW = 9;
  localparam int unsigned CostW = 32;
  localparam int unsigned ValW = 48;
  localparam logic signed [ValW-1:0] Inf = 48'sh1000_0000_0000;
  localparam logic [0:0] RegRows = 1'b0;
  localparam logic [0:0] RegCols = 1'b1;

  typedef enum logic [3:0] {
    S_LOAD, S_SHIFT_RD, S_SHIFT_WR, S_ROW_INIT, S_SCAN_RD, S_SCAN,
    S_PICK, S_DUAL, S_AUG, S_EMIT
  } state_e;

  typedef logic signed [ValW-1:0] val_t;
endpackage

### hdl/linear_assignment_solver_unit.sv
// Top level: cost loader, shortest augmenting path solver and result emitter.
// Loading takes one cost item per cycle while s_axis_tvalid is high. The last item starts
// the solve: a shift pass subtracts the minimum from each cost, then per row an init step,
// scan passes over the unscanned columns until a free column wins, a dual update and a walk
// on the augmenting path; then one result per row as m_axis_tready allows (R > C: no solve, all rows failed).
// Throughput: one matrix at a time; input and config held off during solve and emit.
// Reset: asynchronous active low; sizes return to 16x16, minimum to max, load count to 0.
`timescale 1ns / 1ps
`include "linear_assignment_solver_unit_defines.svh"
module linear_assignment_solver_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] cost_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [3:0] row_index, [7:4] assigned_column, [8] status
  output logic        m_axis_tlast,   // last_row
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [4:0]  cfg_data_i
);
  localparam int unsigned IW = las_pkg::IdxW;

  las_pkg::state_e state_q, state_d;

  // Configuration registers, writable only between runs or while loading
  logic [4:0] rows_q, cols_q;
  assign cfg_ready_o = (state_q == las_pkg::S_LOAD);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= 5'd16;
      cols_q <= 5'd16;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == las_pkg::RegRows) rows_q <= cfg_data_i;
      else cols_q <= cfg_data_i;
    end
  end
  logic [4:0] nr, nc;
  assign nr = (rows_q == 5'd0) ? 5'd1 : (rows_q > 5'd16) ? 5'd16 : rows_q;
  assign nc = (cols_q == 5'd0) ? 5'd1 : (cols_q > 5'd16) ? 5'd16 : cols_q;

  // Cost memory: 256 x 33, one write and one registered read per cycle
  logic signed [32:0] cost_mem [256];
  logic        mem_we;
  logic [7:0]  mem_wa, mem_ra;
  logic signed [32:0] mem_wd, mem_rd_q;
  always_ff @(posedge clk_i) begin
    if (mem_we) cost_mem[mem_wa] <= mem_wd;
    mem_rd_q <= cost_mem[mem_ra];
  end

  logic [8:0] load_q;
  logic signed [31:0] min_q;
  logic [8:0] total;
  assign total = 9'(nr) * 9'(nc);

  // Solver state
  las_pkg::val_t u_q [16], v_q [16], p_q [16];
  logic [4:0] pred_q [16], cor_q [16], roc_q [16];
  logic [15:0] rvis_q, cvis_q;
  logic [IW-1:0] cur_q, row_q, j_q, sink_q, emit_q;
  logic [7:0] sidx_q;
  las_pkg::val_t minv_q, low_q, rowu_q;
  logic [IW:0] pick_q;
  logic fail_q;
  // Unscanned column list: scanned in list order, a picked entry is
  // replaced by the last one, as in the classic formulation
  logic [IW-1:0] todo_q [16];
  logic [IW:0] rem_q;
  logic [IW-1:0] k_q;

  logic [IW-1:0] scol, pcol;
  assign scol = todo_q[k_q];
  assign pcol = todo_q[pick_q[IW-1:0]];

  logic accept;
  assign s_axis_tready = (state_q == las_pkg::S_LOAD);
  assign accept = s_axis_tvalid && s_axis_tready;
  logic last_in;
  assign last_in = (load_q + 9'd1) >= total;

  logic signed [31:0] newmin;
  assign newmin = ($signed(s_axis_tdata) < min_q) ? $signed(s_axis_tdata) : min_q;

  // Base row address into the cost memory
  logic [7:0] row_base;
  assign row_base = 8'(row_q) * 8'(nc);

  // Scan step: column scol, cost arrives on mem_rd_q
  las_pkg::val_t red, pj;
  assign red = minv_q + las_pkg::val_t'(mem_rd_q) - rowu_q - v_q[scol];
  assign pj = (red < p_q[scol]) ? red : p_q[scol];
  logic better;
  // equal path cost: a free column wins
  assign better = (pj < low_q) || (pj == low_q && roc_q[scol][4]);

  // Augmenting walk
  logic [IW-1:0] ar;
  assign ar = (pred_q[j_q][4] || pred_q[j_q][IW-1:0] >= nr[IW-1:0] && nr != 5'd16)
              ? '0 : pred_q[j_q][IW-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      las_pkg::S_LOAD:     if (accept && last_in) state_d = las_pkg::S_SHIFT_RD;
      las_pkg::S_SHIFT_RD: state_d = las_pkg::S_SHIFT_WR;
      las_pkg::S_SHIFT_WR:
        if (nr > nc) state_d = las_pkg::S_EMIT;
        else if (sidx_q + 8'd1 >= total[7:0] && total != 9'd256 || sidx_q == 8'd255)
          state_d = las_pkg::S_ROW_INIT;
        else state_d = las_pkg::S_SHIFT_RD;
      las_pkg::S_ROW_INIT: state_d = las_pkg::S_SCAN_RD;
      las_pkg::S_SCAN_RD:  state_d = las_pkg::S_SCAN;
      las_pkg::S_SCAN:
        state_d = (5'(k_q) + 5'd1 >= rem_q) ? las_pkg::S_PICK : las_pkg::S_SCAN_RD;
      las_pkg::S_PICK:
        if (pick_q[IW] || low_q >= las_pkg::Inf) state_d = las_pkg::S_EMIT;
        else if (roc_q[pcol][4]) state_d = las_pkg::S_DUAL;
        else state_d = las_pkg::S_SCAN_RD;
      las_pkg::S_DUAL:     state_d = las_pkg::S_AUG;
      las_pkg::S_AUG:
        if (ar == cur_q)
          state_d = (5'(cur_q) + 5'd1 >= nr) ? las_pkg::S_EMIT : las_pkg::S_ROW_INIT;
      las_pkg::S_EMIT:
        if (m_axis_tready && 5'(emit_q) + 5'd1 >= nr) state_d = las_pkg::S_LOAD;
      default: state_d = las_pkg::S_LOAD;
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = sidx_q;
    mem_wd = mem_rd_q - 33'(min_q);
    mem_ra = sidx_q;
    if (state_q == las_pkg::S_LOAD) begin
      mem_we = accept;
      mem_wa = load_q[7:0];
      mem_wd = 33'($signed(s_axis_tdata));
    end else if (state_q == las_pkg::S_SHIFT_WR) begin
      mem_we = 1'b1;
    end else if (state_q != las_pkg::S_SHIFT_RD) begin
      mem_ra = row_base + 8'(scol);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= las_pkg::S_LOAD;
      load_q <= '0;
      min_q <= 32'sh7FFF_FFFF;
      sidx_q <= '0;
      emit_q <= '0;
      fail_q <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        las_pkg::S_LOAD: if (accept) begin
          load_q <= last_in ? 9'd0 : load_q + 9'd1;
          min_q <= newmin;
          sidx_q <= '0;
          emit_q <= '0;
          fail_q <= 1'b0;
        end
        las_pkg::S_SHIFT_WR: begin
          sidx_q <= sidx_q + 8'd1;
          if (nr > nc) fail_q <= 1'b1;
          for (int k = 0; k < 16; k++) begin
            u_q[k] <= '0; v_q[k] <= '0;
            pred_q[k] <= '1; cor_q[k] <= '1; roc_q[k] <= '1;
          end
          cur_q <= '0;
        end
        las_pkg::S_ROW_INIT: begin
          row_q <= cur_q; rowu_q <= u_q[cur_q]; minv_q <= '0;
          rvis_q <= '0; cvis_q <= '0;
          for (int k = 0; k < 16; k++) begin
            p_q[k] <= las_pkg::Inf;
            todo_q[k] <= IW'(nc - 5'd1 - 5'(k));
          end
          rem_q <= nc; k_q <= '0;
          low_q <= las_pkg::Inf; pick_q <= '1;
        end
        las_pkg::S_SCAN_RD: rvis_q[row_q] <= 1'b1;
        las_pkg::S_SCAN: begin
          if (red < p_q[scol]) begin
            p_q[scol] <= red; pred_q[scol] <= 5'(row_q);
          end
          if (better) begin
            low_q <= pj; pick_q <= 5'(k_q);
          end
          k_q <= k_q + 1'b1;
        end
        las_pkg::S_PICK: begin
          if (pick_q[IW] || low_q >= las_pkg::Inf) fail_q <= 1'b1;
          else begin
            minv_q <= low_q;
            cvis_q[pcol] <= 1'b1;
            sink_q <= pcol;
            row_q <= roc_q[pcol][IW-1:0];
            rowu_q <= u_q[roc_q[pcol][IW-1:0]];
            todo_q[pick_q[IW-1:0]] <= todo_q[IW'(rem_q - 5'd1)];
            rem_q <= rem_q - 5'd1;
            k_q <= '0;
            low_q <= las_pkg::Inf; pick_q <= '1;
          end
        end
        las_pkg::S_DUAL: begin
          for (int k = 0; k < 16; k++) begin
            if (k == int'(cur_q)) u_q[k] <= u_q[k] + minv_q;
            else if (rvis_q[k] && 5'(k) < nr)
              u_q[k] <= u_q[k] + minv_q - p_q[(cor_q[k][4] || cor_q[k] >= nc) ? 4'd0
                                              : cor_q[k][IW-1:0]];
            if (cvis_q[k] && 5'(k) < nc) v_q[k] <= v_q[k] - (minv_q - p_q[k]);
          end
          j_q <= sink_q;
        end
        las_pkg::S_AUG: begin
          roc_q[j_q] <= 5'(ar);
          cor_q[ar] <= 5'(j_q);
          j_q <= (cor_q[ar][4] || cor_q[ar] >= nc) ? '0 : cor_q[ar][IW-1:0];
          if (ar == cur_q) cur_q <= cur_q + 1'b1;
        end
        las_pkg::S_EMIT: if (m_axis_tready) begin
          emit_q <= emit_q + 1'b1;
          // run done: minimum starts over for the next matrix
          if (5'(emit_q) + 5'd1 >= nr) min_q <= 32'sh7FFF_FFFF;
        end
        default: ;
      endcase
    end
  end

  logic [IW-1:0] acol;
  assign acol = (cor_q[emit_q][4] || cor_q[emit_q] >= nc) ? '0 : cor_q[emit_q][IW-1:0];
  assign m_axis_tvalid = (state_q == las_pkg::S_EMIT);
  assign m_axis_tdata = {7'd0, fail_q, fail_q ? 4'd0 : acol, emit_q};
  assign m_axis_tlast = (5'(emit_q) + 5'd1 == nr);

  `LAS_ASSERT(a_no_in_busy, (state_q != las_pkg::S_LOAD) |-> !s_axis_tready,
              "input accepted while solving")
  `LAS_ASSERT(a_out_only_emit, m_axis_tvalid |-> (state_q == las_pkg::S_EMIT),
              "result outside emit")
  `LAS_ASSERT(a_load_bound, (state_q == las_pkg::S_LOAD) |-> (load_q < 9'd256),
              "load count overran")
  `LAS_ASSERT(a_cfg_idle, cfg_ready_o |-> (state_q == las_pkg::S_LOAD),
              "config taken while solving")
  `LAS_ASSERT_KNOWN(a_out_known, m_axis_tvalid, "result valid unknown")
endmodule
